// File: hdl/hla_pkg.sv
// ----------------------------------------------------------------------------
// Hough line accumulator package
// Sizes, command codes, queue entry and config types, sine/cosine tables.
// ----------------------------------------------------------------------------
package hla_pkg;

    localparam int ANGLE_BINS  = 256;
    localparam int RHO_BINS    = 512;
    localparam int COUNT_BITS  = 16;
    localparam int ANG_W       = $clog2(ANGLE_BINS);
    localparam int RHO_W       = $clog2(RHO_BINS);
    localparam int ADDR_W      = ANG_W + RHO_W;
    localparam int PEAK_MARGIN = 5;
    localparam int TRIG_W      = 16;
    localparam int PIX_W       = 12;
    localparam int EDGE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 48;
    localparam int NUM_W       = COUNT_BITS + 8;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_VOTE  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RHO_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RHO_SCALE = 3'd5;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [ANG_W-1:0] angle;
        logic [RHO_W-1:0] rho;
    } t_cmd_entry;

    typedef struct packed {
        logic [PIX_W-1:0]  width;
        logic [PIX_W-1:0]  height;
        logic [EDGE_W-1:0] threshold;
        logic [7:0]        margin;
    } t_front_cfg;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic [ANGLE_BINS-1:0][TRIG_W-1:0] t_trig_rom;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'd1073741824;

    // Q2.30 to Q1.14, clamped to [0, 1], round half up
    function automatic longint to_q14(input longint v);
        longint q;
        q = (v + 64'sd32768) >>> 16;
        if (v <= 0) begin
            q = 0;
        end else if (q > 16384) begin
            q = 16384;
        end
        return q;
    endfunction

    // Taylor term divisor d*(d+1), d from 1 to 16
    function automatic longint unsigned taylor_div(input longint unsigned p, input int d);
        longint unsigned q;
        case (d)
            1:       q = p / 64'd2;
            2:       q = p / 64'd6;
            3:       q = p / 64'd12;
            4:       q = p / 64'd20;
            5:       q = p / 64'd30;
            6:       q = p / 64'd42;
            7:       q = p / 64'd56;
            8:       q = p / 64'd72;
            9:       q = p / 64'd90;
            10:      q = p / 64'd110;
            11:      q = p / 64'd132;
            12:      q = p / 64'd156;
            13:      q = p / 64'd182;
            14:      q = p / 64'd210;
            15:      q = p / 64'd240;
            16:      q = p / 64'd272;
            default: q = p;
        endcase
        return q;
    endfunction

    // Taylor series over the angle folded onto [0, pi/2]
    function automatic t_trig_rom build_trig(input logic want_cos);
        t_trig_rom       rom;
        longint unsigned j, x, x2, term;
        longint          s, c, v;
        logic            upper;
        for (int a = 0; a < ANGLE_BINS; a++) begin
            j = longint'(a);
            upper = 1'b0;
            if (2 * a > ANGLE_BINS) begin
                j = longint'(ANGLE_BINS - a);
                upper = 1'b1;
            end
            x  = (j * PI_Q30) / ANGLE_BINS;
            x2 = (x * x) >> 30;
            s = longint'(x);
            term = x;
            for (int k = 1; k <= 8; k++) begin
                term = taylor_div((term * x2) >> 30, 2 * k);
                s = ((k & 1) != 0) ? s - longint'(term) : s + longint'(term);
            end
            c = ONE_Q30;
            term = ONE_Q30;
            for (int k = 1; k <= 8; k++) begin
                term = taylor_div((term * x2) >> 30, 2 * k - 1);
                c = ((k & 1) != 0) ? c - longint'(term) : c + longint'(term);
            end
            if (want_cos) begin
                v = upper ? -to_q14(c) : to_q14(c);
            end else begin
                v = to_q14(s);
            end
            rom[a] = v[TRIG_W-1:0];
        end
        return rom;
    endfunction

    localparam t_trig_rom SIN_ROM = build_trig(1'b0);
    localparam t_trig_rom COS_ROM = build_trig(1'b1);

endpackage

// File: hdl/hough_line_accumulator.sv
// A clear writes zero to every store entry, one store entry per cycle;
// a vote makes one read-modify-write per angle bin.
// A read makes ten store reads, then runs the divider for its result.
// One command is executed at a time; a four-entry queue holds the ones behind.
// After reset a clearing pass over all RHO_BINS*ANGLE_BINS (131072) entries runs
// before the first item is accepted; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
// Hough line accumulator
// Top level: config registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
module hough_line_accumulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hla_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hla_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // pixel_x, pixel_y,
                                                          // edge_value, angle_index,
                                                          // rho_index
    input  logic [1:0]                     s_axis_tuser,  // command
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [hla_pkg::OUT_DATA_W-1:0] m_axis_tdata   // bin_count, intensity,
                                                          // is_peak, max_count
);
    import hla_pkg::*;

    t_front_cfg r_cfg;
    logic [15:0] r_rho_max, r_rho_scale;
    logic        push, full, q_valid, pop, init_busy;
    t_cmd_entry  push_entry, q_entry;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width     <= 12'd640;
            r_cfg.height    <= 12'd480;
            r_cfg.threshold <= 8'd100;
            r_cfg.margin    <= 8'd10;
            r_rho_max       <= 16'd12800;
            r_rho_scale     <= 16'd20972;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:     r_cfg.width     <= i_cfg_data[11:0];
                REG_HEIGHT:    r_cfg.height    <= i_cfg_data[11:0];
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data[7:0];
                REG_MARGIN:    r_cfg.margin    <= i_cfg_data[7:0];
                REG_RHO_MAX:   r_rho_max       <= i_cfg_data;
                REG_RHO_SCALE: r_rho_scale     <= i_cfg_data;
                default: begin end
            endcase
        end
    end

    hla_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg         (r_cfg),
        .i_queue_full  (full),
        .i_init_busy   (init_busy),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    hla_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_entry),
        .i_pop   (pop)
    );

    hla_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (q_valid),
        .i_entry       (q_entry),
        .o_pop         (pop),
        .i_rho_max     (r_rho_max),
        .i_rho_scale   (r_rho_scale),
        .o_init_busy   (init_busy),
        .o_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .o_res_data    (m_axis_tdata)
    );

endmodule

// File: hdl/hla_fifo.sv
// ----------------------------------------------------------------------------
// Hough command queue
// Four-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module hla_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hla_pkg::t_cmd_entry i_data,
    output logic                o_full,
    output logic                o_valid,
    output hla_pkg::t_cmd_entry o_data,
    input  logic                i_pop
);
    import hla_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_cmd_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/hla_front.sv
// ----------------------------------------------------------------------------
// Hough front end
// Accepts commands, drops the unused command code and votes outside the region or not above the threshold.
// ----------------------------------------------------------------------------
module hla_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [55:0]         s_axis_tdata,  // x, y, edge, angle, rho
    input  logic [1:0]          s_axis_tuser,  // command
    input  hla_pkg::t_front_cfg i_cfg,
    input  logic                i_queue_full,
    input  logic                i_init_busy,
    output logic                o_push,
    output hla_pkg::t_cmd_entry o_entry
);
    import hla_pkg::*;

    logic [PIX_W-1:0]  x, y;
    logic [EDGE_W-1:0] edge_val;
    logic [PIX_W:0]    x_end, y_end;
    logic              in_region, keep;

    assign x        = s_axis_tdata[11:0];
    assign y        = s_axis_tdata[23:12];
    assign edge_val = s_axis_tdata[31:24];

    // margin <= x < width - margin, same for y
    assign x_end = {1'b0, x} + {5'b0, i_cfg.margin};
    assign y_end = {1'b0, y} + {5'b0, i_cfg.margin};
    assign in_region = (x >= {4'b0, i_cfg.margin}) && (x_end < {1'b0, i_cfg.width})
                    && (y >= {4'b0, i_cfg.margin}) && (y_end < {1'b0, i_cfg.height});

    // classify
    always_comb begin
        unique case (s_axis_tuser)
            CMD_CLEAR: keep = 1'b1;
            CMD_READ:  keep = 1'b1;
            CMD_VOTE:  keep = in_region && (edge_val > i_cfg.threshold);
            default:   keep = 1'b0;
        endcase
    end

    assign s_axis_tready = !i_queue_full && !i_init_busy;
    assign o_push        = s_axis_tvalid && s_axis_tready && keep;

    assign o_entry.cmd   = s_axis_tuser;
    assign o_entry.x     = x;
    assign o_entry.y     = y;
    assign o_entry.angle = s_axis_tdata[39:32];
    assign o_entry.rho   = s_axis_tdata[48:40];

endmodule

// File: hdl/hla_div.sv
// ----------------------------------------------------------------------------
// Hough intensity divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hla_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [hla_pkg::NUM_W-1:0]          i_num,
    input  logic [hla_pkg::COUNT_BITS-1:0]     i_den,
    output logic                               o_done,
    output logic [hla_pkg::NUM_W-1:0]          o_quo
);
    import hla_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [COUNT_BITS:0]  r_rem, trial, n_rem;
    logic [NUM_W-1:0]     r_num;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy, r_done, take;

    // one restoring step
    assign trial = {r_rem[COUNT_BITS-1:0], r_num[NUM_W-1]};
    assign take  = (trial >= {1'b0, i_den});
    assign n_rem = take ? trial - {1'b0, i_den} : trial;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NUM_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

// File: hdl/hla_back.sv
// ----------------------------------------------------------------------------
// Hough back end
// Vote store, clearing sweep, vote pipeline and peak readout.
// ----------------------------------------------------------------------------
module hla_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_entry_valid,
    input  hla_pkg::t_cmd_entry i_entry,
    output logic                o_pop,
    input  logic [15:0]         i_rho_max,
    input  logic [15:0]         i_rho_scale,
    output logic                o_init_busy,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [47:0]         o_res_data  // count, intensity, peak, max
);
    import hla_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_VOTE  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [3:0] K_LAST  = 4'd9;
    localparam logic [COUNT_BITS-1:0] CAP = '1;

    logic [2:0]            r_state;
    logic                  r_init;
    logic [ADDR_W-1:0]     r_sweep;
    logic [COUNT_BITS-1:0] r_largest;
    t_cmd_entry            r_cmd;

    logic [COUNT_BITS-1:0] r_mem [RHO_BINS*ANGLE_BINS];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0]     mem_raddr, mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_we;

    // vote pipeline
    logic                  r_issuing;
    logic [ANG_W-1:0]      r_ang;
    logic                  r_v0, r_v1, r_v2, r_v3, r_v4;
    logic [ANG_W-1:0]      r_a0, r_a1, r_a2, r_a3;
    logic [ADDR_W-1:0]     r_addr4;
    t_trig                 r_sin0, r_cos0;
    logic signed [28:0]    r_px1, r_py1;
    logic signed [31:0]    r_t2;
    logic [46:0]           r_prod3;
    logic [16:0]           bin_full;
    logic [RHO_W-1:0]      bin;
    logic [COUNT_BITS-1:0] inc;

    // read sequence
    logic [3:0]            r_k, r_dk;
    logic                  r_dv, r_peak;
    logic [COUNT_BITS-1:0] r_val;
    logic [7:0]            r_inten;
    logic [3:0]            g;
    logic [RHO_W-1:0]      rd_rho;
    logic [ANG_W-1:0]      rd_ang;
    logic                  in_margin;

    logic                  div_start, div_done;
    logic [NUM_W-1:0]      div_quo;
    logic                  load_res;
    logic [47:0]           r_res;
    logic                  r_res_valid;

    assign o_pop       = (r_state == S_IDLE) && i_entry_valid;
    assign o_init_busy = r_init;

    // rho bin of the stage 3 product, clamped
    assign bin_full = r_prod3[46:30];
    assign bin = (bin_full > 17'(RHO_BINS - 1)) ? RHO_W'(RHO_BINS - 1) : bin_full[RHO_W-1:0];
    assign inc = (r_rdata == CAP) ? r_rdata : r_rdata + 1'b1;

    // read offsets: center first, then the 3x3 neighborhood
    assign g = r_k - 4'd1;
    always_comb begin
        rd_rho = r_cmd.rho;
        rd_ang = r_cmd.angle;
        if (r_k != '0) begin
            unique case (g)
                4'd0: begin rd_rho = r_cmd.rho - 1'b1; rd_ang = r_cmd.angle - 1'b1; end
                4'd1: begin rd_rho = r_cmd.rho - 1'b1; end
                4'd2: begin rd_rho = r_cmd.rho - 1'b1; rd_ang = r_cmd.angle + 1'b1; end
                4'd3: begin rd_ang = r_cmd.angle - 1'b1; end
                4'd4: begin end
                4'd5: begin rd_ang = r_cmd.angle + 1'b1; end
                4'd6: begin rd_rho = r_cmd.rho + 1'b1; rd_ang = r_cmd.angle - 1'b1; end
                4'd7: begin rd_rho = r_cmd.rho + 1'b1; end
                4'd8: begin rd_rho = r_cmd.rho + 1'b1; rd_ang = r_cmd.angle + 1'b1; end
                default: begin end
            endcase
        end
    end

    assign in_margin = (r_cmd.rho >= RHO_W'(PEAK_MARGIN))
                    && (r_cmd.rho < RHO_W'(RHO_BINS - PEAK_MARGIN))
                    && (r_cmd.angle >= ANG_W'(PEAK_MARGIN))
                    && (r_cmd.angle < ANG_W'(ANGLE_BINS - PEAK_MARGIN));

    // memory port selection
    assign mem_raddr = (r_state == S_READ) ? {rd_rho, rd_ang} : {bin, r_a3};
    assign mem_we    = (r_state == S_CLEAR) || r_v4;
    assign mem_waddr = (r_state == S_CLEAR) ? r_sweep : r_addr4;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : inc;

    // vote store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // vote datapath
    always_ff @(posedge i_clk) begin
        r_a0    <= r_ang;
        r_sin0  <= SIN_ROM[r_ang];
        r_cos0  <= COS_ROM[r_ang];
        r_a1    <= r_a0;
        r_px1   <= $signed({1'b0, r_cmd.x}) * r_cos0;
        r_py1   <= $signed({1'b0, r_cmd.y}) * r_sin0;
        r_a2    <= r_a1;
        r_t2    <= 32'(r_px1) + 32'(r_py1) + $signed({6'b0, i_rho_max, 10'b0});
        r_a3    <= r_a2;
        r_prod3 <= r_t2[31] ? '0 : 47'(r_t2[30:0]) * 47'(i_rho_scale);
        r_addr4 <= {bin, r_a3};
    end

    // read sequence datapath
    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            if (r_dk == '0) begin
                r_val <= r_rdata;
            end
        end
        if (div_done) begin
            r_inten <= div_quo[7:0];
        end
        if (load_res) begin
            r_res <= {7'b0, r_largest, r_peak, r_inten, r_val};
        end
    end

    assign div_start = (r_state == S_READ) && r_dv && (r_dk == K_LAST);
    assign load_res  = (r_state == S_OUT) && (!r_res_valid || i_res_ready);

    hla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_val, 8'b0} - NUM_W'(r_val)),
        .i_den   (r_largest),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_largest   <= COUNT_BITS'(1);
            r_issuing   <= 1'b0;
            r_ang       <= '0;
            {r_v0, r_v1, r_v2, r_v3, r_v4} <= '0;
            r_k         <= '0;
            r_dk        <= '0;
            r_dv        <= 1'b0;
            r_peak      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_v0 <= r_issuing;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_v4 && (inc > r_largest)) begin
                r_largest <= inc;
            end
            if (r_issuing) begin
                r_ang <= r_ang + 1'b1;
                if (r_ang == ANG_W'(ANGLE_BINS - 1)) begin
                    r_issuing <= 1'b0;
                end
            end
            r_dv <= 1'b0;
            if (load_res) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == '1) begin
                        r_state <= S_IDLE;
                        r_init  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_entry_valid) begin
                        r_cmd <= i_entry;
                        unique case (i_entry.cmd)
                            CMD_CLEAR: begin
                                r_state   <= S_CLEAR;
                                r_sweep   <= '0;
                                r_largest <= COUNT_BITS'(1);
                            end
                            CMD_VOTE: begin
                                r_state   <= S_VOTE;
                                r_issuing <= 1'b1;
                                r_ang     <= '0;
                            end
                            CMD_READ: begin
                                r_state <= S_READ;
                                r_k     <= '0;
                            end
                            default: begin end
                        endcase
                    end
                end
                S_VOTE: begin
                    if (!r_issuing && !r_v0 && !r_v1 && !r_v2 && !r_v3 && !r_v4) begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (r_k == '0) begin
                        r_peak <= in_margin;
                    end
                    if (r_k <= K_LAST) begin
                        r_k  <= r_k + 1'b1;
                        r_dv <= 1'b1;
                        r_dk <= r_k;
                    end
                    if (r_dv) begin
                        if (r_dk == '0) begin
                            if (r_rdata <= (r_largest >> 1)) begin
                                r_peak <= 1'b0;
                            end
                        end else if (r_rdata > r_val) begin
                            r_peak <= 1'b0;
                        end
                        if (r_dk == K_LAST) begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (load_res) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res;

`ifndef ASSERT_OFF
    a_largest_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_largest != '0) else $error("largest count is zero");
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_issuing && !r_v4)) else $error("vote pipe busy in idle");
    a_intensity_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (div_quo[NUM_W-1:8] == '0)) else $error("intensity overflow");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE) || ($past(i_entry.cmd) != CMD_VOTE))
        else $error("vote not started");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hough line accumulator testbench
// Drives clear, vote, read and unused commands over the input stream, with config
// writes between phases, and checks every read result field by field
// against an in-bench vote store model. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import hla_pkg::*;

    typedef struct {
        bit [15:0] count;
        bit [7:0]  inten;
        bit        peak;
        bit [15:0] maxc;
    } t_bin_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // pixel_x, pixel_y, edge_value, angle, rho
    logic [1:0]            s_axis_tuser;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // bin_count, intensity, is_peak, max_count

    hough_line_accumulator dut (.*);

    // predictor state
    bit [15:0]   vote_counts [RHO_BINS*ANGLE_BINS];
    int unsigned top_count;
    int          sin_q14 [ANGLE_BINS];
    int          cos_q14 [ANGLE_BINS];
    int          img_w, img_h, thresh, margin;
    longint      rho_off, rho_gain;
    t_bin_report pending_reads [$];
    int          fails;
    bit          no_idle;
    int          stall_left;
    int          line_x, line_y;

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // overall limit
    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    // sine/cosine tables: Taylor series in Q2.30, folded onto [0, pi/2]
    function automatic void build_trig();
        longint unsigned j, x, x2, st, ct;
        longint          s, c, q;
        bit              up;
        for (int a = 0; a < ANGLE_BINS; a++) begin
            up = (2 * a > ANGLE_BINS);
            j  = up ? ANGLE_BINS - a : a;
            x  = (j * 64'd3373259426) / ANGLE_BINS;
            x2 = (x * x) >> 30;
            s  = x;
            st = x;
            c  = 64'd1073741824;
            ct = 64'd1073741824;
            for (int k = 1; k <= 8; k++) begin
                st = ((st * x2) >> 30) / ((2 * k) * (2 * k + 1));
                ct = ((ct * x2) >> 30) / ((2 * k - 1) * (2 * k));
                s  = (k % 2) ? s - longint'(st) : s + longint'(st);
                c  = (k % 2) ? c - longint'(ct) : c + longint'(ct);
            end
            q = (s <= 0) ? 0 : (s + 32768) >>> 16;
            sin_q14[a] = (q > 16384) ? 16384 : q;
            q = (c <= 0) ? 0 : (c + 32768) >>> 16;
            q = (q > 16384) ? 16384 : q;
            cos_q14[a] = up ? -q : q;
        end
    endfunction

    function automatic int rho_bin_of(int x, int y, int a);
        longint t;
        longint unsigned b;
        t = longint'(x) * cos_q14[a] + longint'(y) * sin_q14[a] + (rho_off << 10);
        if (t < 0) return 0;
        b = (longint'(t) * rho_gain) >> 30;
        return (b > RHO_BINS - 1) ? RHO_BINS - 1 : int'(b);
    endfunction

    function automatic void clear_store();
        foreach (vote_counts[i]) vote_counts[i] = '0;
        top_count = 1;
    endfunction

    function automatic void cast_vote(int x, int y, int e);
        int idx;
        if (e <= thresh) return;
        if (x < margin || x >= img_w - margin) return;
        if (y < margin || y >= img_h - margin) return;
        for (int a = 0; a < ANGLE_BINS; a++) begin
            idx = rho_bin_of(x, y, a) * ANGLE_BINS + a;
            if (vote_counts[idx] != 16'hFFFF) vote_counts[idx]++;
            if (vote_counts[idx] > top_count) top_count = vote_counts[idx];
        end
    endfunction

    function automatic t_bin_report read_bin(int a, int r);
        t_bin_report rep;
        int unsigned v;
        v = vote_counts[r * ANGLE_BINS + a];
        rep.count = v;
        rep.inten = (longint'(v) * 255) / top_count;
        rep.maxc  = top_count;
        rep.peak  = (r >= PEAK_MARGIN && r < RHO_BINS - PEAK_MARGIN &&
                     a >= PEAK_MARGIN && a < ANGLE_BINS - PEAK_MARGIN &&
                     v > top_count / 2);
        if (rep.peak)
            for (int dr = -1; dr <= 1; dr++)
                for (int da = -1; da <= 1; da++)
                    if (vote_counts[(r + dr) * ANGLE_BINS + a + da] > v) rep.peak = 0;
        return rep;
    endfunction

    // send one command transaction; predict on acceptance
    task automatic send_cmd(logic [1:0] cmd, int x = 0, int y = 0, int e = 0,
                            int a = 0, int r = 0);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, r[8:0], a[7:0], e[7:0], y[11:0], x[11:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        case (cmd)
            CMD_CLEAR: clear_store();
            CMD_VOTE:  cast_vote(x, y, e);
            CMD_READ:  pending_reads.push_back(read_bin(a, r));
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_WIDTH:     img_w    = val;
            REG_HEIGHT:    img_h    = val;
            REG_THRESHOLD: thresh   = val;
            REG_MARGIN:    margin   = val;
            REG_RHO_MAX:   rho_off  = val;
            REG_RHO_SCALE: rho_gain = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(int w, int h, int th, int m, int rm, int rs);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_THRESHOLD, th);
        write_reg(REG_MARGIN, m);
        write_reg(REG_RHO_MAX, rm);
        write_reg(REG_RHO_SCALE, rs);
    endtask

    // a trailing read drains everything ahead of it; then the block is idle
    task automatic drain();
        send_cmd(CMD_READ, 0, 0, 0, 0, 0);
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_bin_report exp_rep;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (pending_reads.size() == 0) begin
                $error("unexpected result transaction");
                fails++;
            end else begin
                exp_rep = pending_reads.pop_front();
                if (m_axis_tdata[15:0] != exp_rep.count) begin
                    $error("bin_count exp %0d got %0d", exp_rep.count, m_axis_tdata[15:0]);
                    fails++;
                end
                if (m_axis_tdata[23:16] != exp_rep.inten) begin
                    $error("intensity exp %0d got %0d", exp_rep.inten, m_axis_tdata[23:16]);
                    fails++;
                end
                if (m_axis_tdata[24] != exp_rep.peak) begin
                    $error("is_peak exp %0d got %0d", exp_rep.peak, m_axis_tdata[24]);
                    fails++;
                end
                if (m_axis_tdata[40:25] != exp_rep.maxc) begin
                    $error("max_count exp %0d got %0d", exp_rep.maxc, m_axis_tdata[40:25]);
                    fails++;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 19);
            m_axis_tready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= (stall_left == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // margins, threshold, unused command, clear, peak window edges
    task automatic test_directed();
        send_cmd(CMD_READ, 0, 0, 0, 0, 0);
        send_cmd(2'd3, 4095, 4095, 255, 255, 511);
        send_cmd(CMD_VOTE, 320, 240, 100);
        repeat (3) send_cmd(CMD_VOTE, 320, 240, 101);
        send_cmd(CMD_VOTE, 10, 10, 255);
        send_cmd(CMD_VOTE, 629, 469, 200);
        send_cmd(CMD_VOTE, 630, 240, 200);
        send_cmd(CMD_VOTE, 320, 470, 200);
        send_cmd(CMD_VOTE, 9, 240, 200);
        send_cmd(CMD_VOTE, 320, 9, 200);
        send_cmd(CMD_VOTE, 4095, 4095, 255);
        send_cmd(CMD_VOTE, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0, rho_bin_of(320, 240, 0));
        send_cmd(CMD_READ, 0, 0, 0, 64, rho_bin_of(320, 240, 64));
        send_cmd(CMD_READ, 0, 0, 0, 128, rho_bin_of(320, 240, 128));
        send_cmd(CMD_READ, 0, 0, 0, 5, rho_bin_of(320, 240, 5));
        send_cmd(CMD_READ, 0, 0, 0, 250, rho_bin_of(320, 240, 250));
        send_cmd(CMD_READ, 0, 0, 0, 4, rho_bin_of(320, 240, 4));
        send_cmd(CMD_READ, 0, 0, 0, 255, 511);
        send_cmd(CMD_READ, 0, 0, 0, 255, rho_bin_of(10, 10, 255));
        send_cmd(CMD_CLEAR);
        send_cmd(CMD_READ, 0, 0, 0, 64, rho_bin_of(320, 240, 64));
        drain();
    endtask

    // register extremes: full image, no margin, saturated rho, empty region
    task automatic test_config_extremes();
        write_all(4095, 4095, 0, 0, 65535, 65535);
        send_cmd(CMD_VOTE, 0, 0, 1);
        send_cmd(CMD_VOTE, 4095, 4095, 255);
        send_cmd(CMD_VOTE, 4095, 0, 1);
        send_cmd(CMD_VOTE, 0, 4095, 1);
        send_cmd(CMD_READ, 0, 0, 0, 100, 511);
        send_cmd(CMD_READ, 0, 0, 0, 0, rho_bin_of(0, 0, 0));
        drain();
        write_reg(REG_RHO_MAX, 0);
        send_cmd(CMD_VOTE, 4095, 0, 9);
        send_cmd(CMD_READ, 0, 0, 0, 200, 0);
        send_cmd(CMD_READ, 0, 0, 0, 10, rho_bin_of(4095, 0, 10));
        drain();
        write_reg(REG_RHO_SCALE, 0);
        write_reg(REG_THRESHOLD, 255);
        send_cmd(CMD_VOTE, 100, 100, 255);
        send_cmd(CMD_READ, 0, 0, 0, 30, 0);
        drain();
        write_all(510, 20, 0, 255, 12800, 20972);
        send_cmd(CMD_VOTE, 255, 10, 200);
        send_cmd(CMD_READ, 0, 0, 0, 30, 0);
        drain();
        write_all(1, 1, 0, 0, 100, 40000);
        send_cmd(CMD_VOTE, 0, 0, 1);
        send_cmd(CMD_VOTE, 1, 0, 1);
        send_cmd(CMD_READ, 0, 0, 0, 7, rho_bin_of(0, 0, 7));
        drain();
    endtask

    // mostly collinear pixel runs and reads around their bins, plus noise
    task automatic test_lines(int n, int w, int h, int th, int m);
        int rm, sx, sy, k, a, pick;
        rm = (w + h) * 16;
        if (rm < 4200) rm = 4200;
        if (rm > 65535) rm = 65535;
        write_all(w, h, th, m, rm, 268435456 / rm);
        send_cmd(CMD_CLEAR);
        k = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) == 0) no_idle = ~no_idle;
            if (k == 0) begin
                line_x = $urandom_range(m, w - 1);
                line_y = $urandom_range(m, h - 1);
                sx = $urandom_range(0, 6) - 3;
                sy = $urandom_range(0, 6) - 3;
                k  = $urandom_range(5, 25);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                line_x += sx;
                line_y += sy;
                k--;
                send_cmd(CMD_VOTE, line_x & 12'hFFF, line_y & 12'hFFF,
                         $urandom_range(th, 255));
            end else if (pick < 85) begin
                a = $urandom_range(0, 255);
                send_cmd(CMD_READ, 0, 0, 0, a,
                         (rho_bin_of(line_x & 12'hFFF, line_y & 12'hFFF, a)
                          + $urandom_range(0, 2) + 511) % 512);
            end else if (pick < 93) begin
                send_cmd(CMD_READ, 0, 0, 0, $urandom_range(0, 255), $urandom_range(0, 511));
            end else if (pick < 98) begin
                send_cmd(CMD_VOTE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 255));
            end else begin
                send_cmd(2'd3, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 511));
            end
        end
        no_idle = 0;
        drain();
    endtask

    initial begin
        fails         = 0;
        no_idle       = 0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        img_w = 640; img_h = 480; thresh = 100; margin = 10;
        rho_off = 12800; rho_gain = 20972;
        build_trig();
        clear_store();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_lines(560, 640, 480, 100, 10);
        test_lines(560, $urandom_range(100, 4095), $urandom_range(100, 4095),
                   $urandom_range(0, 200), $urandom_range(0, 30));
        test_lines(560, 300, 200, 0, 0);

        repeat (300) @(posedge i_clk);
        if (fails == 0 && pending_reads.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
